// File: hdl/cmf_pkg.sv
// Shared constants and types of the centred median filter.
package cmf_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int BIT_CNT_W   = $clog2(SAMPLE_W);
	localparam int CNT_W       = 5;
	localparam int CNT_MAX     = 31;
	localparam int WIN_CFG_W   = 4;
	localparam int WIN_RESET   = 5;
	localparam int MAX_WINDOW  = 15;

	// Status of the bit-serial selector as seen by the controller.
	typedef struct packed {
		logic busy;
		logic done;
	} sel_stat_t;

endpackage

// File: hdl/centered_median_filter_top.sv
// Top level of the centred median filter: control, configuration and output register.
// An item that yields one result is transferred, selected bit-serially over its 16 bits
// and registered in the output register; no new item is taken while a selection runs.
// A last item yields up to half+1 results, each selected after the previous one is loaded.
// The bit-serial selector paces these results; the output register holds a result
// while the next item is taken. Asynchronous reset clears control and count and sets window size 5.
module centered_median_filter_top #(
	parameter int MAX_WINDOW = cmf_pkg::MAX_WINDOW
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cmf_pkg::WIN_CFG_W-1:0]        cfg_data,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [cmf_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                 last,
	output logic                                 median_valid,
	input  logic                                 median_stall,
	output logic signed [cmf_pkg::SAMPLE_W-1:0]  median,
	output logic                                 last_res
);

	// Length width for the store, and a wider width for window arithmetic so
	// that count, window length and their sums never overflow.
	localparam int LW  = $clog2(MAX_WINDOW + 1);
	localparam int AW  = ((LW > cmf_pkg::CNT_W) ? LW : cmf_pkg::CNT_W) + 1;
	// The largest odd window that fits in the store.
	localparam int CAP = ((MAX_WINDOW % 2) == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_OUT
	} state_t;

	state_t                          state_q;
	logic [cmf_pkg::WIN_CFG_W-1:0]   win_size_q;
	logic [cmf_pkg::CNT_W-1:0]       count_q;
	logic [cmf_pkg::CNT_W-1:0]       fcnt_q;
	logic [AW-1:0]                   d_q;
	logic                            flush_q;
	logic                            out_valid_q;
	logic signed [cmf_pkg::SAMPLE_W-1:0] out_data_q;
	logic                            out_last_q;

	logic                            accept;
	logic [cmf_pkg::CNT_W-1:0]       cnt_n;
	logic [AW-1:0]                   cnt_a;
	logic [AW-1:0]                   ws_a;
	logic [AW-1:0]                   m_a;
	logic [AW-1:0]                   half_a;
	logic [AW-1:0]                   r_a;
	logic [AW-1:0]                   d0_a;
	logic [AW-1:0]                   len_nf;
	logic [AW-1:0]                   len_f0;
	logic [AW-1:0]                   len_c;
	logic [AW-1:0]                   sum_f0;
	logic [AW-1:0]                   sum_c;
	logic [AW-1:0]                   fcnt_a;
	logic                            acc_start;
	logic                            out_free;
	logic                            load;
	logic                            more;
	logic                            sel_start;
	logic [LW-1:0]                   sel_len;
	logic [AW-1:0]                   sel_len_a;
	cmf_pkg::sel_stat_t              sel_stat;
	logic [cmf_pkg::SAMPLE_W-1:0]    sel_res;
	logic [MAX_WINDOW-1:0]           win_msb;

	// Always ready; user must see it is written only while the filter is idle; not enforced.
	assign cfg_ready = 1'b1;

	// New samples are taken only while no selection is in flight.
	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;

	always_comb begin
		// Effective window: an even size is raised to odd, then capped by the store.
		ws_a   = AW'(win_size_q | cmf_pkg::WIN_CFG_W'(1));
		m_a    = (ws_a > AW'(CAP)) ? AW'(CAP) : ws_a;
		half_a = m_a >> 1;

		// The received count saturates well above any half window.
		cnt_n = (count_q == cmf_pkg::CNT_W'(cmf_pkg::CNT_MAX)) ? count_q : count_q + 1'b1;
		cnt_a = AW'(cnt_n);

		// Ordinary sample: the window is clipped at the start of the signal.
		len_nf = (cnt_a < m_a) ? cnt_a : m_a;

		// Last sample: the flush starts at the oldest pending position and
		// the window is clipped at both ends.
		r_a    = (cnt_a < half_a + 1'b1) ? cnt_a : half_a + 1'b1;
		d0_a   = r_a - 1'b1;
		sum_f0 = d0_a + half_a + 1'b1;
		len_f0 = (sum_f0 > cnt_a) ? cnt_a : sum_f0;

		// Following flush positions, one step nearer the newest sample.
		fcnt_a = AW'(fcnt_q);
		sum_c  = d_q + half_a;
		len_c  = (sum_c > fcnt_a) ? fcnt_a : sum_c;

		acc_start = accept && (last || (cnt_a > half_a));
		out_free  = !out_valid_q || !median_stall;
		load      = ((state_q == ST_RUN && sel_stat.done) || state_q == ST_OUT) && out_free;
		more      = flush_q && (d_q != '0);
		sel_start = acc_start || (load && more);

		if (acc_start) begin
			sel_len_a = last ? len_f0 : len_nf;
		end else begin
			sel_len_a = len_c;
		end
		sel_len = sel_len_a[LW-1:0];
	end

	// The single clocked block holds state, bookkeeping and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_size_q  <= cmf_pkg::WIN_CFG_W'(cmf_pkg::WIN_RESET);
			count_q     <= '0;
			fcnt_q      <= '0;
			d_q         <= '0;
			flush_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				win_size_q <= cfg_data;
			end

			// A result that has been transferred leaves the output register,
			// unless a fresh one replaces it in the same cycle.
			if (out_valid_q && !median_stall && !load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// The count restarts once the last sample closes the signal.
						count_q <= last ? '0 : cnt_n;
						if (acc_start) begin
							state_q <= ST_RUN;
							flush_q <= last;
							d_q     <= last ? d0_a : '0;
							fcnt_q  <= cnt_n;
						end
					end
				end
				ST_RUN, ST_OUT: begin
					if (load) begin
						out_valid_q <= 1'b1;
						out_data_q  <= $signed(sel_res);
						out_last_q  <= flush_q && (d_q == '0);
						if (more) begin
							d_q     <= d_q - 1'b1;
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (state_q == ST_RUN && sel_stat.done) begin
						// The selector holds its result until the output register frees.
						state_q <= ST_OUT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	cmf_window #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_window (
		.clk       (clk),
		.push      (accept),
		.push_data (sample),
		.rotate    (sel_stat.busy),
		.msb       (win_msb)
	);

	cmf_select #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_select (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sel_start),
		.len    (sel_len),
		.msb    (win_msb),
		.stat   (sel_stat),
		.result (sel_res)
	);

	assign median_valid = out_valid_q;
	assign median       = out_data_q;
	assign last_res     = out_last_q;

endmodule

// File: hdl/cmf_window.sv
// Sample store: a line of rotating shift registers that presents one bit of each entry.
module cmf_window #(
	parameter int MAX_WINDOW = cmf_pkg::MAX_WINDOW
) (
	input  logic                          clk,
	input  logic                          push,
	input  logic [cmf_pkg::SAMPLE_W-1:0]  push_data,
	input  logic                          rotate,
	output logic [MAX_WINDOW-1:0]         msb
);

	logic [cmf_pkg::SAMPLE_W-1:0] entry_q [MAX_WINDOW];

	// A push moves whole words along the line; a rotation turns every word
	// left by one bit, so sixteen rotations restore the store.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[0] <= push_data;
			for (int i = 1; i < MAX_WINDOW; i++) begin
				entry_q[i] <= entry_q[i-1];
			end
		end else if (rotate) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				entry_q[i] <= {entry_q[i][cmf_pkg::SAMPLE_W-2:0],
					entry_q[i][cmf_pkg::SAMPLE_W-1]};
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			msb[i] = entry_q[i][cmf_pkg::SAMPLE_W-1];
		end
	end

endmodule

// File: hdl/cmf_select.sv
// Bit-serial rank selector: finds the upper median of the newest entries, MSB first.
module cmf_select #(
	parameter int MAX_WINDOW = cmf_pkg::MAX_WINDOW,
	localparam int LW        = $clog2(MAX_WINDOW + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [LW-1:0]                 len,
	input  logic [MAX_WINDOW-1:0]         msb,
	output cmf_pkg::sel_stat_t            stat,
	output logic [cmf_pkg::SAMPLE_W-1:0]  result
);

	logic                            busy_q;
	logic                            done_q;
	logic [cmf_pkg::BIT_CNT_W-1:0]   bit_q;
	logic [MAX_WINDOW-1:0]           mask_q;
	logic [LW-1:0]                   rank_q;
	logic [cmf_pkg::SAMPLE_W-1:0]    res_q;

	logic                            first;
	logic [MAX_WINDOW-1:0]           bits_eff;
	logic [MAX_WINDOW-1:0]           zeros;
	logic [LW-1:0]                   count0;
	logic                            take_one;
	logic [MAX_WINDOW-1:0]           init_mask;

	always_comb begin
		// The sign bit is inverted so that signed order matches unsigned order.
		first    = (bit_q == '0);
		bits_eff = msb ^ {MAX_WINDOW{first}};
		zeros    = mask_q & ~bits_eff;
		count0   = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			count0 = count0 + LW'(zeros[i]);
		end
		take_one = (rank_q >= count0);
		for (int i = 0; i < MAX_WINDOW; i++) begin
			init_mask[i] = (LW'(i) < len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
			end else if (busy_q) begin
				bit_q <= bit_q + 1'b1;
				if (bit_q == cmf_pkg::BIT_CNT_W'(cmf_pkg::SAMPLE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mask_q <= init_mask;
			rank_q <= len >> 1;
		end else if (busy_q) begin
			if (take_one) begin
				mask_q <= mask_q & bits_eff;
				rank_q <= rank_q - count0;
			end else begin
				mask_q <= zeros;
			end
			res_q <= {res_q[cmf_pkg::SAMPLE_W-2:0], take_one ^ first};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = res_q;

endmodule

// File: verif/median_check_pkg.sv
// Expected-median tracker for the centred median filter testbench.
package median_check_pkg;

	import cmf_pkg::*;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct {
		sample_t median;
		logic    last_res;
	} median_result_t;

	class median_tracker;
		sample_t              history[MAX_WINDOW];
		int unsigned          seen;
		logic [WIN_CFG_W-1:0] window;
		median_result_t       pending_medians[$];
		int unsigned          failures;

		function new();
			window   = WIN_CFG_W'(WIN_RESET);
			seen     = 0;
			failures = 0;
			foreach (history[i]) history[i] = '0;
		endfunction

		function void set_window(logic [WIN_CFG_W-1:0] w);
			window = w;
		endfunction

		function int unsigned pending();
			return pending_medians.size();
		endfunction

		// The length in use is always odd and never longer than the store.
		function int unsigned span();
			int unsigned m;
			int unsigned cap;
			m   = window | 1;
			cap = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
			return (m > cap) ? cap : m;
		endfunction

		// Upper middle of the newest len samples, found by a plain insertion sort.
		function sample_t middle_of(int unsigned len);
			sample_t pool[MAX_WINDOW];
			sample_t v;
			int      n;
			int      i;
			int      j;
			n = len;
			for (i = 0; i < n; i++) pool[i] = history[i];
			for (i = 1; i < n; i++) begin
				v = pool[i];
				j = i;
				while (j > 0 && pool[j-1] > v) begin
					pool[j] = pool[j-1];
					j--;
				end
				pool[j] = v;
			end
			return pool[n / 2];
		endfunction

		function void take_sample(sample_t s, logic fin);
			int unsigned    m;
			int unsigned    half;
			int unsigned    r;
			int unsigned    d;
			int unsigned    len;
			median_result_t res;
			m    = span();
			half = m / 2;
			for (int k = MAX_WINDOW - 1; k > 0; k--) history[k] = history[k-1];
			history[0] = s;
			if (seen < CNT_MAX) seen++;
			if (!fin) begin
				if (seen > half) begin
					res.median   = middle_of((seen < m) ? seen : m);
					res.last_res = 1'b0;
					pending_medians.push_back(res);
				end
			end else begin
				// The flush emits the trailing positions, oldest first, with shrinking windows.
				r = (seen < half + 1) ? seen : half + 1;
				for (int k = 0; k < r; k++) begin
					d   = r - 1 - k;
					len = d + half + 1;
					if (len > seen) len = seen;
					res.median   = middle_of(len);
					res.last_res = (d == 0);
					pending_medians.push_back(res);
				end
				seen = 0;
			end
		endfunction

		function void match_median(sample_t got, logic got_last, time stamp);
			median_result_t want;
			if (pending_medians.size() == 0) begin
				$display("%0t: median %0d last_res %0b arrived, expected none",
					stamp, got, got_last);
				failures++;
				return;
			end
			want = pending_medians.pop_front();
			if (got !== want.median) begin
				$display("%0t: median expected %0d, actual %0d", stamp, want.median, got);
				failures++;
			end
			if (got_last !== want.last_res) begin
				$display("%0t: last_res expected %0b, actual %0b",
					stamp, want.last_res, got_last);
				failures++;
			end
		endfunction
	endclass

endpackage

// File: verif/tb_top.sv
// Self-checking testbench of the centred median filter with random flow control.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import cmf_pkg::*;
	import median_check_pkg::*;

	// A flush at the widest window gives eight results, each delayed further by receiver
	// stalls; this limit leaves ample margin for the whole run.
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Cycles to let pass once nothing more is expected, covering an item still in flight.
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned RANDOM_ITEMS = 95;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [WIN_CFG_W-1:0] cfg_data     = '0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	sample_t              sample       = '0;
	logic                 last         = 1'b0;
	logic                 median_valid;
	logic                 median_stall = 1'b0;
	sample_t              median;
	logic                 last_res;

	// While calm is set neither side idles, giving one stretch at full rate.
	bit            calm = 1'b0;
	int unsigned   cycles = 0;
	median_tracker tracker = new();

	centered_median_filter_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.last         (last),
		.median_valid (median_valid),
		.median_stall (median_stall),
		.median       (median),
		.last_res     (last_res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The run is bounded by a cycle count so that a hung handshake still ends it.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Result side. Values read at the edge are those from before it, since every signal
	// on both sides changes through nonblocking assignments. A result is taken when valid
	// is high and stall is low; the stall for the following cycle is then drawn afresh.
	always @(posedge clk) begin
		if (arst_n && median_valid && !median_stall)
			tracker.match_median(median, last_res, $time);
		median_stall <= !calm && ($urandom_range(0, 99) < 28);
	end

	// Edge values are favoured, and a narrow band around zero gives many equal samples,
	// so that ties in the selection are exercised as well as wide spreads.
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2, 3:    return sample_t'($signed($urandom_range(0, 8)) - 4);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// Offers one sample and returns at the edge where it is transferred. Beforehand the
	// sender may idle for a random gap, or now and then hold off until every expected
	// median has come out. Valid is only lowered when an idle gap follows,
	// so it is never lowered and raised within the same time step.
	task automatic send_item(input sample_t s, input logic fin);
		int unsigned gap;
		bit          hold;
		gap  = 0;
		hold = !calm && ($urandom_range(0, 39) == 0);
		if (!calm && $urandom_range(0, 99) < 28)
			gap = $urandom_range(1, 5);
		if (hold && gap == 0)
			gap = 1;
		if (gap != 0) begin
			sample_valid <= 1'b0;
			if (hold)
				while (tracker.pending() != 0) @(posedge clk);
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		last         <= fin;
		do @(posedge clk); while (sample_stall);
		tracker.take_sample(s, fin);
	endtask

	// A signal of random content; left open, it carries on into the next phase.
	task automatic send_signal(input int unsigned len, input bit close);
		for (int unsigned i = 0; i < len; i++)
			send_item(pick_sample(), close && (i == len - 1));
	endtask

	// The window register is only written while the filter is idle: the sender stops,
	// every expected median is drained, and a settling pause covers a sample that is
	// still being worked on without giving a result.
	task automatic write_window(input logic [WIN_CFG_W-1:0] w);
		sample_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_window(w);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned          random_items;
		int unsigned          phase;
		int unsigned          signals;
		int unsigned          len;
		bit                   close;
		logic [WIN_CFG_W-1:0] w;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part. At the reset window of five: the extreme samples, ending in a
		// flush of three trailing medians.
		send_item(16'sh7FFF, 1'b0);
		send_item(16'sh8000, 1'b0);
		send_item(16'shFFFF, 1'b0);
		send_item(16'sh0000, 1'b0);
		send_item(16'sh0001, 1'b1);
		// A signal of a single sample, flushed at once.
		send_item(16'sh1234, 1'b1);

		// A zero window behaves as a window of one: every median is its own sample.
		write_window(4'd0);
		send_item(16'sh8000, 1'b0);
		send_item(16'sh7FFF, 1'b1);

		// The widest window on a signal shorter than it, so every median is clipped.
		write_window(4'd15);
		send_item(16'sh0100, 1'b0);
		send_item(16'shFF00, 1'b0);
		send_item(16'sh0100, 1'b0);
		send_item(16'sh7FFF, 1'b1);

		// An even setting rounds up to fifteen; the flush then gives the most results.
		write_window(4'd14);
		for (int i = 0; i < 7; i++)
			send_item(pick_sample(), 1'b0);
		send_item(pick_sample(), 1'b1);

		// The window changes part-way through a signal.
		write_window(4'd2);
		for (int i = 0; i < 3; i++)
			send_item(pick_sample(), 1'b0);
		write_window(4'd9);
		send_item(pick_sample(), 1'b0);
		send_item(pick_sample(), 1'b1);

		// Random part, in phases of one window setting each. Most signals are well-formed
		// runs of moderate length; a few are very short, some are left open across a
		// window change, and one long signal drives the sample count into saturation.
		random_items = 0;
		phase        = 0;
		while (random_items < RANDOM_ITEMS) begin
			case (phase)
				0:       w = 4'd1;
				1:       w = 4'd15;
				2:       w = 4'd0;
				default: w = WIN_CFG_W'($urandom_range(0, 15));
			endcase
			write_window(w);
			calm    = (phase == 3);
			signals = $urandom_range(1, 3);
			for (int unsigned k = 0; k < signals; k++) begin
				if (phase == 4 && k == 0)
					len = $urandom_range(33, 40);
				else if ($urandom_range(0, 4) == 0)
					len = $urandom_range(1, 2);
				else
					len = $urandom_range(3, 16);
				close = ($urandom_range(0, 99) < 85);
				send_signal(len, close);
				random_items += len;
			end
			phase++;
		end
		calm = 1'b0;

		// Drain everything still expected, then allow for a stray late result.
		sample_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
